// ----- rtl/dspc_pkg.sv -----
package dspc_pkg;

  // Largest modulus that the residue histogram supports.
  localparam int MAX_MODULUS = 64;

  // Field widths.
  localparam int VALUE_W = 32;
  localparam int MOD_W   = 7;
  localparam int BIN_W   = 32;
  localparam int TOTAL_W = 63;

  // Width that holds an effective modulus 1..MAX_MODULUS.
  localparam int K_W = $clog2(MAX_MODULUS + 1);
  // Width of a bin index 0..MAX_MODULUS-1.
  localparam int IDX_W = (MAX_MODULUS > 1) ? $clog2(MAX_MODULUS) : 1;
  // Width used to compare the raw register against the limit.
  localparam int CMP_W = (K_W > MOD_W) ? K_W : MOD_W;
  // Bit counter of the remainder unit.
  localparam int DIV_CNT_W = $clog2(VALUE_W);

  // Queue between the front and back parts.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [MOD_W-1:0]   modulus_t;
  typedef logic [K_W-1:0]     k_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [BIN_W-1:0]   bin_t;
  typedef logic [TOTAL_W-1:0] total_t;

  // One classified item handed from the front part to the back part.
  typedef struct packed {
    idx_t residue;
    idx_t comp;
    logic last;
  } qentry_t;

endpackage

// ----- rtl/dspc_ram.sv -----
module dspc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/dspc_front.sv -----
module dspc_front (
  input  logic              clk,
  input  logic              rst,
  input  dspc_pkg::modulus_t modulus,
  input  logic              in_valid,
  output logic              in_stall,
  input  dspc_pkg::value_t  value,
  input  logic              last,
  output logic              push,
  output dspc_pkg::qentry_t push_entry,
  input  logic              q_full
);

  import dspc_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t                state;
  fstate_t                state_next;
  value_t                 value_sr;
  logic                   last_q;
  k_t                     k;
  k_t                     k_eff;
  k_t                     rem;
  logic [K_W:0]           shifted;
  logic [K_W:0]           rem_step;
  logic [DIV_CNT_W-1:0]   cnt;
  logic [CMP_W-1:0]       mod_ext;
  k_t                     comp_full;

  assign in_stall = (state != F_IDLE);

  // Effective modulus: zero acts as one, large values clip to the limit.
  always_comb begin
    mod_ext = CMP_W'(modulus);
    if (mod_ext == '0) begin
      k_eff = K_W'(1);
    end else if (mod_ext > CMP_W'(MAX_MODULUS)) begin
      k_eff = K_W'(MAX_MODULUS);
    end else begin
      k_eff = K_W'(mod_ext);
    end
  end

  // One restoring step: bring in the next value bit, subtract k if it fits.
  always_comb begin
    shifted = {rem, value_sr[VALUE_W-1]};
    if (shifted >= {1'b0, k}) begin
      rem_step = shifted - {1'b0, k};
    end else begin
      rem_step = shifted;
    end
  end

  // Complementary residue (k - r) mod k.
  assign comp_full = (rem == '0) ? '0 : (k - rem);

  assign push               = (state == F_PUSH) && !q_full;
  assign push_entry.residue = IDX_W'(rem);
  assign push_entry.comp    = IDX_W'(comp_full);
  assign push_entry.last    = last_q;

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (in_valid) begin
          state_next = F_DIV;
        end
      end
      F_DIV: begin
        if (cnt == DIV_CNT_W'(VALUE_W - 1)) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Operand and remainder registers of the iterative unit.
  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (in_valid) begin
          value_sr <= value;
          last_q   <= last;
          k        <= k_eff;
          rem      <= '0;
          cnt      <= '0;
        end
      end
      F_DIV: begin
        rem      <= K_W'(rem_step);
        value_sr <= {value_sr[VALUE_W-2:0], 1'b0};
        cnt      <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/dspc_queue.sv -----
module dspc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dspc_pkg::qentry_t push_entry,
  output logic              full,
  input  logic              pop,
  output dspc_pkg::qentry_t head,
  output logic              empty
);

  import dspc_pkg::*;

  qentry_t             entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

// ----- rtl/dspc_back.sv -----
module dspc_back (
  input  logic              clk,
  input  logic              rst,
  input  dspc_pkg::qentry_t head,
  input  logic              q_empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output dspc_pkg::total_t  pair_count,
  output logic              set_done
);

  import dspc_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_COMP = 3'b010,
    B_OWN  = 3'b100
  } bstate_t;

  localparam total_t TOTAL_MAX = '1;
  localparam bin_t   BIN_MAX   = '1;

  bstate_t                state;
  bstate_t                state_next;
  idx_t                   r_idx;
  idx_t                   c_idx;
  logic                   last_q;
  total_t                 total;
  logic [MAX_MODULUS-1:0] bin_valid;
  logic                   out_free;
  logic                   finish;
  idx_t                   rd_addr;
  bin_t                   rd_data;
  bin_t                   comp_bin;
  bin_t                   own_bin;
  bin_t                   own_bin_next;
  logic [TOTAL_W:0]       sum;

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == B_IDLE) && !q_empty;
  assign finish   = (state == B_OWN) && out_free;

  // The complementary bin is read first, then the item's own bin.
  assign rd_addr = (state == B_IDLE) ? head.comp : r_idx;

  dspc_ram #(
    .WIDTH (BIN_W),
    .DEPTH (MAX_MODULUS)
  ) u_bins (
    .clk     (clk),
    .wr_en   (finish),
    .wr_addr (r_idx),
    .wr_data (own_bin_next),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // A bin not yet written in this set reads as zero.
  assign comp_bin = bin_valid[c_idx] ? rd_data : '0;
  assign own_bin  = bin_valid[r_idx] ? rd_data : '0;
  assign own_bin_next = (own_bin == BIN_MAX) ? own_bin : own_bin + 1'b1;

  // Saturating add of the complementary count to the total.
  assign sum = {1'b0, total} + (TOTAL_W + 1)'(comp_bin);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          state_next = B_COMP;
        end
      end
      B_COMP: state_next = B_OWN;
      B_OWN: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Control state, histogram valid bits, total and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      bin_valid <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_COMP) begin
        total <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
      end
      if (finish) begin
        out_valid <= 1'b1;
        if (last_q) begin
          bin_valid <= '0;
          total     <= '0;
        end else begin
          bin_valid[r_idx] <= 1'b1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item fields and result payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      r_idx  <= head.residue;
      c_idx  <= head.comp;
      last_q <= head.last;
    end
    if (finish) begin
      pair_count <= total;
      set_done   <= last_q;
    end
  end

endmodule

// ----- rtl/divisible_sum_pair_counter_top.sv -----
// Divisible-sum pair counter.
// Input channel: in_valid/in_stall with value (32 bits) and last. Output
// channel: out_valid/out_stall with pair_count (63 bits) and set_done. A
// transaction completes at a clock edge where valid is high and stall is low.
// Each input transaction yields exactly one output transaction holding the
// running number of pairs in the current set whose sum is a multiple of the
// modulus; set_done echoes last, and after it the histogram and total clear.
// The modulus is written through cfg_wr_en/cfg_wr_data; the user must do so
// only while the block is idle, which the block itself does not enforce.
// The bit-serial remainder unit in the front part (one value bit per cycle)
// takes a new value only after it has pushed the last one into the queue; the
// back part does the read-modify-write of the bin memory, and a two-entry
// queue sits between them. Synchronous reset rst sets the modulus to 2,
// empties the queue and the histogram and drops out_valid; no clearing pass
// is needed.
// While out_stall is high the result holds; the front part keeps working and
// the queue fills before in_stall backs up to the sender.
module divisible_sum_pair_counter_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  dspc_pkg::modulus_t   cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dspc_pkg::value_t     value,
  input  logic                 last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dspc_pkg::total_t     pair_count,
  output logic                 set_done
);

  import dspc_pkg::*;

  modulus_t modulus;
  logic     push;
  qentry_t  push_entry;
  logic     q_full;
  logic     pop;
  qentry_t  head;
  logic     q_empty;

  // Modulus register.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_W'(2);
    end else if (cfg_wr_en) begin
      modulus <= cfg_wr_data;
    end
  end

  dspc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .modulus    (modulus),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .last       (last),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  dspc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty)
  );

  dspc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pair_count (pair_count),
    .set_done   (set_done)
  );

endmodule

// ----- rtl/dspc_checker.sv -----
module dspc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input dspc_pkg::value_t   value,
  input logic               last,
  input logic               out_valid,
  input logic               out_stall,
  input dspc_pkg::total_t   pair_count,
  input logic               set_done
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pair_count) && $stable(set_done))
    else $error("stalled result changed");

  // A stalled input transaction keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(value) && $stable(last))
    else $error("stalled input changed");

  // Reset leaves no result pending and the input side open.
  assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("state after reset wrong");

  // The remainder unit is busy right after it takes a transaction.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while remainder unit busy");

endmodule

bind divisible_sum_pair_counter_top dspc_checker u_checker (.*);

// ----- tb/tb_divisible_sum_pair_counter_top.sv -----
module tb_divisible_sum_pair_counter_top;
  import dspc_pkg::*;

  // Pair totals saturate at the largest 63-bit value.
  localparam logic [63:0] TOTAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  // Length of the long receiver hold-off.
  localparam int HOLD_CYCLES = 500;
  // Items in each random phase.
  localparam int PHASE_ITEMS = 140;

  typedef struct {
    value_t value;
    logic   last;
  } item_t;

  typedef struct {
    total_t pair_count;
    logic   set_done;
  } result_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cfg_wr_en = 1'b0;
  modulus_t cfg_wr_data = '0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  value_t   value = '0;
  logic     last = 1'b0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  total_t   pair_count;
  logic     set_done;

  // Stimulus and scoreboard storage.
  item_t   pending_items[$];
  result_t expected_results[$];
  item_t   next_item;
  result_t oldest_result;

  // Shadow copy of the block's histogram, total and modulus register.
  bin_t     tb_residue_bins [MAX_MODULUS];
  total_t   tb_pair_total;
  modulus_t tb_modulus;

  // Idling controls, set between phases.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  int fail_count = 0;
  int idle_cycles = 0;

  divisible_sum_pair_counter_top uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pair_count (pair_count),
    .set_done   (set_done)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Zero and out-of-range register values map onto 1..MAX_MODULUS.
  function automatic int unsigned effective_modulus(input modulus_t m);
    int unsigned k;
    k = m;
    if (k == 0) k = 1;
    if (k > MAX_MODULUS) k = MAX_MODULUS;
    return k;
  endfunction

  function automatic void clear_histogram();
    foreach (tb_residue_bins[i]) tb_residue_bins[i] = '0;
    tb_pair_total = '0;
  endfunction

  // Adds the complementary bin to the total, then counts this value's residue.
  function automatic result_t predict_pair_count(input value_t v, input logic lst);
    int unsigned k;
    int unsigned r;
    int unsigned comp;
    logic [63:0] add;
    result_t res;
    k = effective_modulus(tb_modulus);
    r = v % k;
    comp = (k - r) % k;
    add = {32'b0, tb_residue_bins[comp]};
    if ({1'b0, tb_pair_total} > TOTAL_MAX - add) tb_pair_total = TOTAL_MAX[TOTAL_W-1:0];
    else tb_pair_total = tb_pair_total + add[TOTAL_W-1:0];
    if (tb_residue_bins[r] != '1) tb_residue_bins[r] = tb_residue_bins[r] + 1'b1;
    res.pair_count = tb_pair_total;
    res.set_done = lst;
    if (lst) clear_histogram();
    return res;
  endfunction

  // Driver: predicts each accepted transaction and offers the next pending item.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tb_modulus = 7'd2;
      clear_histogram();
    end else begin
      if (cfg_wr_en) tb_modulus = cfg_wr_data;
      if (in_valid && !in_stall)
        expected_results.insert(expected_results.size(), predict_pair_count(value, last));
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_items.pop_front();
          in_valid <= 1'b1;
          value <= next_item.value;
          last <= next_item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: compares each output transaction with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: pair_count %0d, set_done %0b", pair_count, set_done);
        fail_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (pair_count !== oldest_result.pair_count) begin
          $error("pair_count mismatch: expected %0d, actual %0d",
                 oldest_result.pair_count, pair_count);
          fail_count++;
        end
        if (set_done !== oldest_result.set_done) begin
          $error("set_done mismatch: expected %0b, actual %0b",
                 oldest_result.set_done, set_done);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_item(input value_t v, input logic lst);
    item_t it;
    it.value = v;
    it.last = lst;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic write_modulus(input modulus_t m);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every item has gone in and every result has come out.
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mix of full-range, small, multiple-of-k and near-maximum values.
  function automatic value_t random_value(input int unsigned k);
    value_t v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom_range(200);
      2: v = k * $urandom_range(1000) + $urandom_range(2);
      default: v = 32'hFFFF_FFFF - $urandom_range(100);
    endcase
    return v;
  endfunction

  initial begin
    modulus_t phase_moduli [10];
    modulus_t m;
    int unsigned k;
    int set_left;
    phase_moduli = '{7'd7, 7'd64, 7'd1, 7'd0, 7'd127, 7'd3, 7'd65, 7'd2, 7'd13, 7'd100};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset modulus of two.
    push_item(32'h0000_0000, 1'b0);
    push_item(32'hFFFF_FFFF, 1'b0);
    push_item(32'h0000_0001, 1'b0);
    push_item(32'h0000_0003, 1'b0);
    push_item(32'h0000_0002, 1'b1);
    wait_idle();

    // A zero modulus behaves as one, so every pair counts.
    write_modulus(7'd0);
    push_item(32'd5, 1'b0);
    push_item(32'd9, 1'b0);
    push_item(32'hFFFF_FFFF, 1'b1);
    wait_idle();

    // A register value above the limit saturates to the largest modulus.
    write_modulus(7'd127);
    push_item(32'd64, 1'b0);
    push_item(32'd0, 1'b0);
    push_item(32'd63, 1'b0);
    push_item(32'd1, 1'b0);
    push_item(32'hFFFF_FFFF, 1'b0);
    push_item(32'h8000_0000, 1'b1);
    wait_idle();

    // A set of a single element.
    write_modulus(7'd1);
    push_item(32'd7, 1'b1);
    wait_idle();

    // The modulus changes in the middle of a set; bins keep their counts.
    write_modulus(7'd6);
    push_item(32'd2, 1'b0);
    push_item(32'd4, 1'b0);
    wait_idle();
    write_modulus(7'd5);
    push_item(32'd3, 1'b0);
    push_item(32'd8, 1'b1);
    wait_idle();

    // Random phases; a phase may end in the middle of a set.
    for (int p = 0; p < 10; p++) begin
      m = (p == 7) ? modulus_t'($urandom_range(1, MAX_MODULUS)) : phase_moduli[p];
      write_modulus(m);
      k = effective_modulus(m);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      // One phase holds off the receiver while the sender runs at full rate.
      if (p == 5) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests++;
      end
      set_left = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (set_left == 0)
          set_left = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
        set_left--;
        push_item(random_value(k), set_left == 0);
      end
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
